FILE: sv/asgd_pkg.sv
// Shared types and constants for the strike gesture detector.
// No dependencies; imported by asgd_decide and the top level.
package asgd_pkg;

    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_START_THR = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOW_THR  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_TIME  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TIME  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_LIM  = 3'd4;

    // Reset values of the registers
    localparam logic        [15:0] START_THR_RST = 16'd300;
    localparam logic signed [16:0] BLOW_THR_RST  = -17'sd300;
    localparam logic        [15:0] MIN_TIME_RST  = 16'd100;
    localparam logic        [15:0] MAX_TIME_RST  = 16'd1000;
    localparam logic signed [15:0] AXIS_LIM_RST  = 16'sd100;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_START   = 3'd1,
        EV_HIT     = 3'd2,
        EV_EARLY   = 3'd3,
        EV_TIMEOUT = 3'd4
    } t_event;

    // Outcome of one sample, handed from the decision logic to the state registers
    typedef struct packed {
        logic   hit;
        logic   armed;
        t_event ev;
        logic   clear_ticks;
    } t_decision;

endpackage

FILE: sv/asgd_decide.sv
// Per-sample decision logic: arming, early abort, timeout and blow tests.
// Depends on asgd_pkg; threshold squares come in registered, sample squares
// straight from the multipliers.
module asgd_decide
    import asgd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TIME_WIDTH   = 16
) (
    input  logic                           i_striking,
    input  logic        [TIME_WIDTH-1:0]   i_elapsed,
    input  logic signed [SAMPLE_WIDTH-1:0] i_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_y,
    input  logic signed [SAMPLE_WIDTH:0]   i_sum,
    input  logic        [2*SAMPLE_WIDTH-1:0] i_y_sq,
    input  logic        [2*SAMPLE_WIDTH-1:0] i_z_sq,
    input  logic        [15:0]             i_start_thr,
    input  logic        [31:0]             i_start_sq,
    input  logic signed [16:0]             i_blow_thr,
    input  logic        [33:0]             i_blow_sq,
    input  logic        [15:0]             i_min_time,
    input  logic        [15:0]             i_max_time,
    input  logic signed [15:0]             i_axis_lim,
    output t_decision                      o_dec
);

    localparam int MAG_W = 2 * SAMPLE_WIDTH;
    localparam int CMP_W = (MAG_W > 34) ? MAG_W : 34;
    localparam int AX_W  = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
    localparam int SM_W  = (SAMPLE_WIDTH + 1 > 17) ? SAMPLE_WIDTH + 1 : 17;
    localparam int TC_W  = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

    logic        [MAG_W-1:0] mag2;
    logic        [CMP_W-1:0] mag2_e;
    logic        [CMP_W-1:0] start_sq_e;
    logic        [CMP_W-1:0] blow_sq_e;
    logic                    neg;
    logic signed [AX_W-1:0]  x_e;
    logic signed [AX_W-1:0]  y_e;
    logic signed [AX_W-1:0]  lim_e;
    logic signed [SM_W-1:0]  sum_e;
    logic signed [SM_W-1:0]  half_e;
    logic        [TC_W-1:0]  et_e;
    logic        [TC_W-1:0]  min_e;
    logic        [TC_W-1:0]  max_e;
    logic                    start_now;
    logic                    st1;
    logic                    early;
    logic                    timeout;
    logic                    st2;
    logic                    blow_pos;
    logic                    below_blow;
    logic                    hit;

    assign mag2       = i_y_sq + i_z_sq;
    assign mag2_e     = CMP_W'(mag2);
    assign start_sq_e = CMP_W'(i_start_sq);
    assign blow_sq_e  = CMP_W'(i_blow_sq);
    assign neg        = i_sum[SAMPLE_WIDTH];

    assign x_e    = AX_W'(i_x);
    assign y_e    = AX_W'(i_y);
    assign lim_e  = AX_W'(i_axis_lim);
    assign sum_e  = SM_W'(i_sum);
    assign half_e = signed'(SM_W'(i_start_thr >> 1));

    assign start_now = !i_striking && !neg && (mag2_e > start_sq_e);
    assign st1       = i_striking || start_now;
    // arming clears the tick count seen by the later tests
    assign et_e      = start_now ? '0 : TC_W'(i_elapsed);
    assign min_e     = TC_W'(i_min_time);
    assign max_e     = TC_W'(i_max_time);

    assign early   = st1 && (et_e < min_e) && (sum_e < half_e) &&
                     (x_e < lim_e) && (y_e < lim_e);
    assign timeout = st1 && !early && (et_e > max_e);
    assign st2     = st1 && !early && !timeout;

    assign blow_pos   = !i_blow_thr[16] && (i_blow_thr != '0);
    assign below_blow = blow_pos ? (neg || (mag2_e < blow_sq_e))
                                 : (neg && (mag2_e > blow_sq_e));
    assign hit        = st2 && (et_e >= min_e) && below_blow;

    always_comb begin
        o_dec.hit         = hit;
        o_dec.armed       = st2 && !hit;
        o_dec.clear_ticks = start_now;
        priority if (hit) begin
            o_dec.ev = EV_HIT;
        end else if (timeout) begin
            o_dec.ev = EV_TIMEOUT;
        end else if (early) begin
            o_dec.ev = EV_EARLY;
        end else if (start_now) begin
            o_dec.ev = EV_START;
        end else begin
            o_dec.ev = EV_NONE;
        end
    end

endmodule

FILE: sv/accel_strike_gesture_detector.sv
// Top level of the strike gesture detector: stream ports, configuration
// registers, sample pipeline and strike state. Depends on asgd_pkg, asgd_decide.
//
// Takes one beat per clock unless the result stream stalls: a tick (tuser 0)
// or an accelerometer sample (tuser 1). Each sample loads one result beat
// into the result register once it has passed the input register; ticks give
// none. An input register holds the beat, two multipliers square y and z, and
// the decision logic updates the strike state and loads the result register
// in the same cycle. Both registers advance when the result register is empty
// or being taken, so tready follows the downstream tready. Squared thresholds
// are registered from the configuration registers, so after a write they lag
// behind the registers that the decision logic reads directly.
module accel_strike_gesture_detector
    import asgd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TIME_WIDTH   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: accel_x, accel_y, accel_z (SAMPLE_WIDTH bits each), zero padding
    input  logic [((3 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // tuser: op (0 tick, 1 sample)
    input  logic [0:0]             i_s_axis_tuser,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: hit [0], armed [1], event_res [4:2], zero padding
    output logic [7:0]             o_m_axis_tdata
);

    localparam int SW = SAMPLE_WIDTH;

    // configuration registers
    logic        [15:0] r_start_thr;
    logic signed [16:0] r_blow_thr;
    logic        [15:0] r_min_time;
    logic        [15:0] r_max_time;
    logic signed [15:0] r_axis_lim;
    logic        [31:0] r_start_sq;
    logic        [33:0] r_blow_sq;
    logic        [16:0] w_blow_abs;

    // input register and squares
    logic                   w_en;
    logic                   r_a_valid;
    logic                   r_a_op;
    logic signed [SW-1:0]   r_a_x;
    logic signed [SW-1:0]   r_a_y;
    logic signed [SW-1:0]   r_a_z;
    logic        [2*SW-1:0] w_y_sq;
    logic        [2*SW-1:0] w_z_sq;
    logic signed [SW:0]     w_sum;

    // state and result
    logic                   r_striking;
    logic [TIME_WIDTH-1:0]  r_elapsed;
    logic [TIME_WIDTH-1:0]  n_elapsed;
    logic                   r_out_valid;
    logic [7:0]             r_out_data;
    t_decision              w_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_thr <= START_THR_RST;
            r_blow_thr  <= BLOW_THR_RST;
            r_min_time  <= MIN_TIME_RST;
            r_max_time  <= MAX_TIME_RST;
            r_axis_lim  <= AXIS_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_THR: r_start_thr <= i_cfg_wdata[15:0];
                CFG_BLOW_THR:  r_blow_thr  <= signed'(i_cfg_wdata[16:0]);
                CFG_MIN_TIME:  r_min_time  <= i_cfg_wdata[15:0];
                CFG_MAX_TIME:  r_max_time  <= i_cfg_wdata[15:0];
                CFG_AXIS_LIM:  r_axis_lim  <= signed'(i_cfg_wdata[15:0]);
                default: ;
            endcase
        end
    end

    // squared thresholds, refreshed every cycle from the registers
    assign w_blow_abs = r_blow_thr[16] ? 17'(-r_blow_thr) : 17'(r_blow_thr);

    always_ff @(posedge i_clk) begin
        r_start_sq <= 32'(r_start_thr) * 32'(r_start_thr);
        r_blow_sq  <= 34'(w_blow_abs) * 34'(w_blow_abs);
    end

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_op <= i_s_axis_tuser[0];
            r_a_x  <= signed'(i_s_axis_tdata[SW-1:0]);
            r_a_y  <= signed'(i_s_axis_tdata[2*SW-1:SW]);
            r_a_z  <= signed'(i_s_axis_tdata[3*SW-1:2*SW]);
        end
    end

    assign w_y_sq = r_a_y * r_a_y;
    assign w_z_sq = r_a_z * r_a_z;
    assign w_sum  = (SW+1)'(r_a_y) + (SW+1)'(r_a_z);

    asgd_decide #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_decide (
        .i_striking  (r_striking),
        .i_elapsed   (r_elapsed),
        .i_x         (r_a_x),
        .i_y         (r_a_y),
        .i_sum       (w_sum),
        .i_y_sq      (w_y_sq),
        .i_z_sq      (w_z_sq),
        .i_start_thr (r_start_thr),
        .i_start_sq  (r_start_sq),
        .i_blow_thr  (r_blow_thr),
        .i_blow_sq   (r_blow_sq),
        .i_min_time  (r_min_time),
        .i_max_time  (r_max_time),
        .i_axis_lim  (r_axis_lim),
        .o_dec       (w_dec)
    );

    always_comb begin
        n_elapsed = r_elapsed;
        if (!r_a_op) begin
            // saturate at all ones
            if (r_elapsed != '1) begin
                n_elapsed = r_elapsed + 1'b1;
            end
        end else if (w_dec.clear_ticks) begin
            n_elapsed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_striking  <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_a_valid && r_a_op;
            if (r_a_valid) begin
                r_elapsed <= n_elapsed;
                if (r_a_op) begin
                    r_striking <= w_dec.armed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {3'b000, w_dec.ev, w_dec.armed, w_dec.hit};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: tb/accel_strike_gesture_detector_test.sv
// Self-checking testbench for accel_strike_gesture_detector: a directed table,
// then random phases over register settings and stall patterns.
// Depends on asgd_pkg and the block's RTL only.
`timescale 1ns / 100ps

module accel_strike_gesture_detector_test;
    import asgd_pkg::*;

    localparam int IN_W          = 48;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 90;
    localparam int DRAIN_CYCLES  = 10;
    localparam int QUIET_CYCLES  = 8;

    typedef struct packed {
        logic   hit;
        logic   armed;
        t_event ev;
    } t_strike_res;

    typedef enum logic [1:0] {ROW_TICKS, ROW_SAMPLE, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        int                     arg;      // tick count or register value
        logic [CFG_INDEX_W-1:0] reg_idx;
        int                     x;
        int                     y;
        int                     z;
        bit                     typed;
        t_strike_res            want;
    } t_stim_row;

    typedef struct {
        logic        [15:0] start;
        logic signed [16:0] blow;
        logic        [15:0] tmin;
        logic        [15:0] tmax;
        logic signed [15:0] axis;
    } t_phase_cfg;

    logic                   i_clk;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata     = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32]
    logic [IN_W-1:0]        i_s_axis_tdata  = '0;
    // tuser: op [0]
    logic [0:0]             i_s_axis_tuser  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // tdata: hit [0], armed [1], event_res [4:2], zero padding [7:5]
    logic [7:0]             o_m_axis_tdata;

    accel_strike_gesture_detector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Predictor copy of the registers and the strike state
    logic        [15:0] start_thr = START_THR_RST;
    logic signed [16:0] blow_thr  = BLOW_THR_RST;
    logic        [15:0] min_t     = MIN_TIME_RST;
    logic        [15:0] max_t     = MAX_TIME_RST;
    logic signed [15:0] axis_lim  = AXIS_LIM_RST;
    logic               armed_st  = 1'b0;
    logic        [15:0] tick_cnt  = '0;

    t_strike_res expected_q [$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_req       = 1'b0;
    int  hold_left      = 0;
    int  mismatches     = 0;
    int  cycle_cnt      = 0;
    int  items_sent     = 0;
    int  samples_sent   = 0;
    int  ticks_sent     = 0;
    int  results_seen   = 0;
    int  ev_seen [8];

    t_phase_cfg phase_cfgs [PHASES];

    t_stim_row dir_rows [27] = '{
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      0,      0,      1'b1, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 32767,  32767,  32767,  1'b1, '{1'b0, 1'b1, EV_START}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, -32768, -32768, -32768, 1'b1, '{1'b0, 1'b0, EV_EARLY}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 32767,  -32768, -32768, 1'b1, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      300,    1,      1'b1, '{1'b0, 1'b1, EV_START}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      300,    0,      1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_TICKS,  101,   CFG_START_THR, 0,      0,      0,      1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      -300,   -1,     1'b1, '{1'b1, 1'b0, EV_HIT}},
        // shorten the armed window so the timeout rows stay brief
        '{ROW_REG,    20,    CFG_MAX_TIME,  0,      0,      0,      1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      1000,   0,      1'b1, '{1'b0, 1'b1, EV_START}},
        '{ROW_TICKS,  20,    CFG_START_THR, 0,      0,      0,      1'b0, '{1'b0, 1'b0, EV_NONE}},
        // exactly at max_time: still armed; x above the axis limit blocks an early abort
        '{ROW_SAMPLE, 0,     CFG_START_THR, 200,    50,     50,     1'b1, '{1'b0, 1'b1, EV_NONE}},
        '{ROW_TICKS,  1,     CFG_START_THR, 0,      0,      0,      1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 200,    0,      0,      1'b1, '{1'b0, 1'b0, EV_TIMEOUT}},
        // arms and aborts in the same beat
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      -300,   400,    1'b1, '{1'b0, 1'b0, EV_EARLY}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      2000,   2000,   1'b1, '{1'b0, 1'b1, EV_START}},
        '{ROW_TICKS,  21,    CFG_START_THR, 0,      0,      0,      1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 200,    0,      0,      1'b1, '{1'b0, 1'b0, EV_TIMEOUT}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 12345,  -2000,  700,    1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_REG,    0,     CFG_MIN_TIME,  0,      0,      0,      1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_REG,    0,     CFG_START_THR, 0,      0,      0,      1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      10,     10,     1'b1, '{1'b0, 1'b1, EV_START}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      0,      0,      1'b1, '{1'b0, 1'b1, EV_NONE}},
        // positive blow threshold, zero magnitude counts as non-negative
        '{ROW_REG,    1,     CFG_BLOW_THR,  0,      0,      0,      1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      0,      0,      1'b1, '{1'b1, 1'b0, EV_HIT}},
        '{ROW_REG,    1000,  CFG_BLOW_THR,  0,      0,      0,      1'b0, '{1'b0, 1'b0, EV_NONE}},
        // hit overrides start
        '{ROW_SAMPLE, 0,     CFG_START_THR, 0,      10,     10,     1'b1, '{1'b1, 1'b0, EV_HIT}}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
                     expected_q.size());
            $display("FAIL accel_strike_gesture_detector");
            $finish;
        end
    end

    task automatic log_miss(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // Strike state update for one sample beat
    function automatic t_strike_res judge_sample(logic signed [15:0] x, logic signed [15:0] y,
                                                 logic signed [15:0] z);
        longint      mag2;
        longint      sum;
        longint      b2;
        bit          neg;
        bit          below;
        t_strike_res r;
        mag2 = longint'(y) * longint'(y) + longint'(z) * longint'(z);
        sum  = longint'(y) + longint'(z);
        neg  = sum < 0;
        r    = '{1'b0, 1'b0, EV_NONE};
        if (!armed_st && !neg && mag2 > longint'(start_thr) * longint'(start_thr)) begin
            armed_st = 1'b1;
            tick_cnt = '0;
            r.ev     = EV_START;
        end
        if (armed_st) begin
            if (tick_cnt < min_t && sum < longint'(start_thr >> 1) &&
                x < axis_lim && y < axis_lim) begin
                armed_st = 1'b0;
                r.ev     = EV_EARLY;
            end else if (tick_cnt > max_t) begin
                armed_st = 1'b0;
                r.ev     = EV_TIMEOUT;
            end
        end
        b2    = longint'(blow_thr) * longint'(blow_thr);
        below = (blow_thr > 0) ? (neg || mag2 < b2) : (neg && mag2 > b2);
        if (armed_st && tick_cnt >= min_t && below) begin
            armed_st = 1'b0;
            r.hit    = 1'b1;
            r.ev     = EV_HIT;
        end
        r.armed = armed_st;
        return r;
    endfunction

    // Offer one beat, hold it until taken, then predict
    task automatic send_beat(logic op, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, bit typed, t_strike_res want);
        t_strike_res r;
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {z, y, x};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
        if (op) begin
            samples_sent++;
            r = judge_sample(x, y, z);
            expected_q.push_back(typed ? want : r);
        end else begin
            ticks_sent++;
            if (tick_cnt != 16'hFFFF)
                tick_cnt++;
        end
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_beat(1'b0, $urandom(), $urandom(), $urandom(), 1'b0, '0);
    endtask

    // Drop valid and let every sample and tick drain out
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_START_THR: start_thr = val[15:0];
            CFG_BLOW_THR:  blow_thr  = val;
            CFG_MIN_TIME:  min_t     = val[15:0];
            CFG_MAX_TIME:  max_t     = val[15:0];
            CFG_AXIS_LIM:  axis_lim  = val[15:0];
            default: ;
        endcase
    endtask

    function automatic int pick_up_to(int lim);
        return $urandom_range(0, (lim > 32767) ? 32767 : lim);
    endfunction

    // Result side: compare every beat, then drive tready for the next edge
    always @(posedge i_clk) begin : result_check
        t_strike_res got;
        t_strike_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{o_m_axis_tdata[0], o_m_axis_tdata[1], t_event'(o_m_axis_tdata[4:2])};
            results_seen++;
            ev_seen[o_m_axis_tdata[4:2]]++;
            if (expected_q.size() == 0) begin
                log_miss($sformatf("unexpected result beat hit %0b armed %0b ev %0d",
                                   got.hit, got.armed, got.ev));
            end else begin
                want = expected_q.pop_front();
                if (got.hit != want.hit || got.armed != want.armed || got.ev != want.ev)
                    log_miss($sformatf(
                        "result %0d: expected hit %0b armed %0b ev %0d, got %0b %0b %0d",
                        results_seen, want.hit, want.armed, want.ev,
                        got.hit, got.armed, got.ev));
            end
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int phase_goal;
        int bmag;
        int burst_cap;
        int pick;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_TICKS:  send_ticks(dir_rows[i].arg);
                ROW_REG: begin
                    settle();
                    set_reg(dir_rows[i].reg_idx, dir_rows[i].arg[CFG_DATA_W-1:0]);
                end
                default: send_beat(1'b1, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                                   dir_rows[i].typed, dir_rows[i].want);
            endcase
        end

        phase_cfgs[0] = '{16'd300,   -17'sd300,   16'd3,     16'd12,    16'sd100};
        phase_cfgs[1] = '{16'd0,     17'sd0,      16'd0,     16'd0,     -16'sd32768};
        phase_cfgs[2] = '{16'd65535, -17'sd65536, 16'd65535, 16'd65535, 16'sd32767};
        phase_cfgs[3] = '{16'd1000,  -17'sd1000,  16'd2,     16'd8,     16'sd0};
        phase_cfgs[4] = '{16'd200,   17'sd65535,  16'd1,     16'd5,     16'sd32767};
        for (int p = 5; p < PHASES; p++) begin
            phase_cfgs[p].start = $urandom_range(0, 3000);
            phase_cfgs[p].blow  = ($urandom_range(3) == 0) ? $urandom_range(0, 2000)
                                                           : -$urandom_range(0, 3000);
            phase_cfgs[p].tmin  = $urandom_range(0, 8);
            phase_cfgs[p].tmax  = $urandom_range(0, 25);
            phase_cfgs[p].axis  = $urandom();
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            set_reg(CFG_START_THR, phase_cfgs[p].start);
            set_reg(CFG_BLOW_THR,  phase_cfgs[p].blow);
            set_reg(CFG_MIN_TIME,  phase_cfgs[p].tmin);
            set_reg(CFG_MAX_TIME,  phase_cfgs[p].tmax);
            set_reg(CFG_AXIS_LIM,  phase_cfgs[p].axis);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            // long downstream hold while beats keep coming, to back up the pipeline
            if (p == 0)
                hold_req = 1'b1;
            bmag      = (blow_thr < 0) ? -int'(blow_thr) : int'(blow_thr);
            burst_cap = (max_t > 38) ? 40 : int'(max_t) + 2;
            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    // arm, wait some ticks, maybe noise, then a backward blow
                    pick = pick_up_to(start_thr + start_thr / 3 + 20);
                    send_beat(1'b1, $urandom_range(0, 800) - 400, pick,
                              pick_up_to(start_thr + start_thr / 3 + 20), 1'b0, '0);
                    send_ticks($urandom_range(0, burst_cap));
                    if ($urandom_range(1))
                        send_beat(1'b1, $urandom_range(0, 800) - 400,
                                  $urandom_range(0, 800) - 400,
                                  $urandom_range(0, 800) - 400, 1'b0, '0);
                    send_beat(1'b1, $urandom_range(0, 800) - 400,
                              -pick_up_to(bmag + bmag / 3 + 20),
                              -pick_up_to(bmag + bmag / 3 + 20), 1'b0, '0);
                end else if (pick < 65) begin
                    send_beat(1'b1, $urandom(), $urandom(), $urandom(), 1'b0, '0);
                end else if (pick < 85) begin
                    send_beat(1'b1, $urandom_range(0, 800) - 400,
                              $urandom_range(0, 800) - 400,
                              $urandom_range(0, 800) - 400, 1'b0, '0);
                end else begin
                    send_ticks($urandom_range(1, burst_cap));
                end
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_q.size() != 0)
            log_miss($sformatf("%0d expected results never arrived", expected_q.size()));

        $display("covered %0d samples and %0d ticks over %0d register settings, %0d mismatches",
                 samples_sent, ticks_sent, PHASES + 1, mismatches);
        $display("results: %0d total, %0d starts, %0d hits, %0d early aborts, %0d timeouts",
                 results_seen, ev_seen[EV_START], ev_seen[EV_HIT], ev_seen[EV_EARLY],
                 ev_seen[EV_TIMEOUT]);
        if (mismatches == 0)
            $display("PASS accel_strike_gesture_detector");
        else
            $display("FAIL accel_strike_gesture_detector");
        $finish;
    end

endmodule
